FILE: src/bted_pkg.sv
package bted_pkg;

  localparam int RADIUS     = 2;
  localparam int WIN        = 2 * RADIUS + 1;
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;

  localparam int PIX_W  = 8;
  localparam int WID_W  = 11;
  localparam int HGT_W  = 13;
  localparam int OROW_W = 12;
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT + 6 * RADIUS + 1) + 1;
  localparam int STK_W  = 2 * RADIUS;

  localparam int LAG_MUL = 3 * RADIUS;
  localparam int PRE_W   = $clog2(LAG_MUL * (MAX_WIDTH + 1) + 1);

  localparam int FIFO_DEPTH = 16;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam logic [PIX_W-1:0] THRESHOLD_RESET = 8'd100;
  localparam logic [WID_W-1:0] WIDTH_RESET     = 11'd640;
  localparam logic [HGT_W-1:0] HEIGHT_RESET    = 13'd480;
  localparam logic [PIX_W-1:0] PIX_ON          = 8'd255;
  localparam logic [PIX_W-1:0] PIX_OFF         = 8'd0;

  typedef enum logic [1:0] {
    REG_THRESHOLD = 2'd0,
    REG_WIDTH     = 2'd1,
    REG_HEIGHT    = 2'd2
  } reg_idx_t;

  // one binary sample travelling between window stages, tagged with its raster position
  typedef struct packed {
    logic                    vld;
    logic                    val;
    logic signed [ROW_W-1:0] row;
    logic [COL_W-1:0]        col;
  } pos_t;

  typedef struct packed {
    logic [PIX_W-1:0]  pixel;
    logic [OROW_W-1:0] row;
    logic [COL_W-1:0]  col;
    logic              last;
  } result_t;

endpackage

FILE: src/bted_ram.sv
module bted_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 4
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/bted_stage.sv
module bted_stage (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        dilate,
  input  logic [bted_pkg::WID_W-1:0]  width,
  input  logic [bted_pkg::HGT_W-1:0]  height,
  input  bted_pkg::pos_t              din,
  output bted_pkg::pos_t              dout
);
  import bted_pkg::*;

  pos_t                    b;
  logic                    fwd;
  logic [STK_W-1:0]        fwd_data;
  logic [STK_W-1:0]        rdata;
  logic [STK_W-1:0]        old;
  logic [STK_W-1:0]        wdata;
  logic [WIN-1:0]          colv;
  logic [WIN-1:0]          win [WIN-1];
  logic [WIN-1:0]          full [WIN];
  logic signed [ROW_W-1:0] cr;
  logic signed [COL_W+1:0] ccs;
  logic [WIN-1:0]          rmask;
  logic [WIN-1:0]          cmask;
  logic                    acc;

  // per column: the previous rows of this stage's input, newest in bit 0
  bted_ram #(.DEPTH(MAX_WIDTH), .WIDTH(STK_W)) u_ram (
    .clk   (clk),
    .we    (b.vld),
    .waddr (b.col),
    .wdata (wdata),
    .re    (din.vld),
    .raddr (din.col),
    .rdata (rdata)
  );

  always_comb begin
    old   = fwd ? fwd_data : rdata;
    wdata = {old[STK_W-2:0], b.val};
    colv  = {old, b.val};
    for (int j = 0; j < WIN - 1; j++) begin
      full[j] = win[j];
    end
    full[WIN-1] = colv;
  end

  // center lies RADIUS rows and RADIUS raster positions behind the newest sample
  always_comb begin
    cr  = $signed(b.row) - $signed(ROW_W'(RADIUS));
    ccs = $signed({2'b00, b.col});
    for (int i = 0; i < RADIUS; i++) begin
      ccs = ccs - $signed((COL_W + 2)'(1));
      if (ccs < 0) begin
        ccs = ccs + $signed({1'b0, width});
        cr  = cr - $signed(ROW_W'(1));
      end
    end
  end

  always_comb begin
    logic signed [ROW_W:0]   rr;
    logic signed [COL_W+2:0] cx;
    for (int i = 0; i < WIN; i++) begin
      rr = $signed({cr[ROW_W-1], cr}) + $signed((ROW_W + 1)'(RADIUS - i));
      rmask[i] = (rr >= 0) && (rr < $signed((ROW_W + 1)'(height)));
    end
    for (int j = 0; j < WIN; j++) begin
      cx = $signed({ccs[COL_W+1], ccs}) + $signed((COL_W + 3)'(j - RADIUS));
      cmask[j] = (cx >= 0) && (cx < $signed((COL_W + 3)'(width)));
    end
  end

  // positions outside the image drop out of the window
  always_comb begin
    acc = !dilate;
    for (int j = 0; j < WIN; j++) begin
      for (int i = 0; i < WIN; i++) begin
        if (rmask[i] && cmask[j]) begin
          acc = dilate ? (acc | full[j][i]) : (acc & full[j][i]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b.vld    <= 1'b0;
      dout.vld <= 1'b0;
    end else begin
      b.vld    <= din.vld;
      dout.vld <= b.vld && !cr[ROW_W-1];
    end
    b.val    <= din.val;
    b.row    <= din.row;
    b.col    <= din.col;
    // same column read while it is written: take the new word
    fwd      <= b.vld && (b.col == din.col);
    fwd_data <= wdata;
    if (b.vld) begin
      for (int j = 0; j < WIN - 2; j++) begin
        win[j] <= win[j+1];
      end
      win[WIN-2] <= colv;
    end
    dout.val <= acc;
    dout.row <= cr;
    dout.col <= ccs[COL_W-1:0];
  end

endmodule

FILE: src/binary_threshold_erode_erode_dilate.sv
// Binarizes 8-bit grey pixels against a threshold, then runs two 5x5 erosions and one 5x5
// dilation, each stage holding its four previous rows in a column memory read and written
// back once per sample. The block takes one item per clock while the output queue has room;
// a result passes through the input register, each stage's registers and a 16-entry output
// queue, and the result for raster index q comes with item q + 6*width + 6. Once all pixels
// of a frame are in, every item, drain or pixel, yields the next result; for a frame smaller
// than 6*width + 6 pixels the first such item is held while the cascade flushes. Writing the
// width or height abandons the current frame. No clearing pass follows reset.
module binary_threshold_erode_erode_dilate (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bted_pkg::ADDR_W-1:0]   paddr,
  input  logic [bted_pkg::DATA_W-1:0]   pwdata,
  output logic [bted_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          command,
  input  logic [bted_pkg::PIX_W-1:0]    pixel_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bted_pkg::PIX_W-1:0]    pixel_out,
  output logic [bted_pkg::OROW_W-1:0]   out_row,
  output logic [bted_pkg::COL_W-1:0]    out_column,
  output logic                          frame_last
);
  import bted_pkg::*;

  logic [PIX_W-1:0]      threshold;
  logic [WID_W-1:0]      image_width;
  logic [HGT_W-1:0]      image_height;
  logic [WID_W-1:0]      eff_w;
  logic [HGT_W-1:0]      eff_h;
  logic                  cfg_wr;
  reg_idx_t              cfg_idx;
  logic                  geom_wr;

  logic [HGT_W-1:0]      trow;
  logic [COL_W-1:0]      tcol;
  logic                  pix_done;
  logic [PRE_W-1:0]      pre;
  logic [OROW_W-1:0]     orow;
  logic [COL_W-1:0]      ocol;
  logic [PRE_W-1:0]      lag3;
  logic                  pre_sat;
  logic                  room;
  logic                  advance;
  logic                  result_adv;
  logic                  tcol_end;
  logic                  ocol_end;
  logic                  frame_end;

  pos_t                  s0;
  pos_t                  s1;
  pos_t                  s2;
  pos_t                  s3;

  result_t               fifo [FIFO_DEPTH];
  result_t               fifo_in;
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic [FIFO_CNT_W-1:0] fcnt;
  logic [FIFO_CNT_W-1:0] credit;
  logic                  fifo_rd;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign geom_wr = cfg_wr && (cfg_idx == REG_WIDTH || cfg_idx == REG_HEIGHT);

  always_comb begin
    eff_w = image_width;
    if (image_width == '0) begin
      eff_w = WID_W'(1);
    end else if (int'(image_width) > MAX_WIDTH) begin
      eff_w = WID_W'(MAX_WIDTH);
    end
    eff_h = image_height;
    if (image_height == '0) begin
      eff_h = HGT_W'(1);
    end else if (int'(image_height) > MAX_HEIGHT) begin
      eff_h = HGT_W'(MAX_HEIGHT);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold    <= THRESHOLD_RESET;
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_THRESHOLD: threshold    <= pwdata[PIX_W-1:0];
        REG_WIDTH:     image_width  <= pwdata[WID_W-1:0];
        REG_HEIGHT:    image_height <= pwdata[HGT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_THRESHOLD: prdata = DATA_W'(threshold);
      REG_WIDTH:     prdata = DATA_W'(image_width);
      REG_HEIGHT:    prdata = DATA_W'(image_height);
      default:       prdata = '0;
    endcase
  end

  // frame sequencing: which transactions advance the cascade and which yield a result
  assign lag3     = PRE_W'(LAG_MUL) * PRE_W'(eff_w) + PRE_W'(LAG_MUL);
  assign pre_sat  = (pre == lag3);
  assign room     = (credit != FIFO_CNT_W'(FIFO_DEPTH));
  assign tcol_end = ({1'b0, tcol} == eff_w - WID_W'(1));
  assign ocol_end = ({1'b0, ocol} == eff_w - WID_W'(1));

  always_comb begin
    if (!pix_done) begin
      in_ready = command || !pre_sat || room;
      advance  = in_valid && !command && (!pre_sat || room);
    end else begin
      // hold the drain until the flush reaches a result
      in_ready = pre_sat && room;
      advance  = in_valid && (!pre_sat || room);
    end
  end

  assign result_adv = advance && pre_sat;
  assign frame_end  = result_adv && ocol_end &&
                      ({1'b0, orow} == eff_h - HGT_W'(1));

  always_ff @(posedge clk) begin
    if (rst || geom_wr) begin
      trow     <= '0;
      tcol     <= '0;
      pix_done <= 1'b0;
      pre      <= '0;
      orow     <= '0;
      ocol     <= '0;
    end else if (frame_end) begin
      trow     <= '0;
      tcol     <= '0;
      pix_done <= 1'b0;
      pre      <= '0;
      orow     <= '0;
      ocol     <= '0;
    end else if (advance) begin
      if (tcol_end) begin
        tcol <= '0;
        trow <= trow + HGT_W'(1);
      end else begin
        tcol <= tcol + COL_W'(1);
      end
      if (!pix_done && tcol_end && (trow == eff_h - HGT_W'(1))) begin
        pix_done <= 1'b1;
      end
      if (!pre_sat) begin
        pre <= pre + PRE_W'(1);
      end else if (ocol_end) begin
        ocol <= '0;
        orow <= orow + OROW_W'(1);
      end else begin
        ocol <= ocol + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0.vld <= 1'b0;
    end else begin
      s0.vld <= advance;
    end
    s0.val <= !pix_done && (pixel_in > threshold);
    s0.row <= $signed(ROW_W'(trow));
    s0.col <= tcol;
  end

  bted_stage u_erode1 (
    .clk    (clk),
    .rst    (rst),
    .dilate (1'b0),
    .width  (eff_w),
    .height (eff_h),
    .din    (s0),
    .dout   (s1)
  );

  bted_stage u_erode2 (
    .clk    (clk),
    .rst    (rst),
    .dilate (1'b0),
    .width  (eff_w),
    .height (eff_h),
    .din    (s1),
    .dout   (s2)
  );

  bted_stage u_dilate (
    .clk    (clk),
    .rst    (rst),
    .dilate (1'b1),
    .width  (eff_w),
    .height (eff_h),
    .din    (s2),
    .dout   (s3)
  );

  // output queue; credits cover results still inside the cascade
  assign fifo_rd = out_valid && out_ready;

  always_comb begin
    fifo_in.pixel = s3.val ? PIX_ON : PIX_OFF;
    fifo_in.row   = s3.row[OROW_W-1:0];
    fifo_in.col   = s3.col;
    fifo_in.last  = (s3.row == $signed(ROW_W'(eff_h) - ROW_W'(1))) &&
                    ({1'b0, s3.col} == eff_w - WID_W'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fcnt   <= '0;
      credit <= '0;
    end else begin
      if (s3.vld) begin
        wr_ptr <= wr_ptr + FIFO_PTR_W'(1);
      end
      if (fifo_rd) begin
        rd_ptr <= rd_ptr + FIFO_PTR_W'(1);
      end
      fcnt   <= fcnt + FIFO_CNT_W'(s3.vld) - FIFO_CNT_W'(fifo_rd);
      credit <= credit + FIFO_CNT_W'(result_adv) - FIFO_CNT_W'(fifo_rd);
    end
  end

  always_ff @(posedge clk) begin
    if (s3.vld) begin
      fifo[wr_ptr] <= fifo_in;
    end
  end

  assign out_valid  = (fcnt != '0);
  assign pixel_out  = fifo[rd_ptr].pixel;
  assign out_row    = fifo[rd_ptr].row;
  assign out_column = fifo[rd_ptr].col;
  assign frame_last = fifo[rd_ptr].last;

  a_fifo_no_overflow: assert property (@(posedge clk) disable iff (rst)
    s3.vld |-> (fcnt != FIFO_CNT_W'(FIFO_DEPTH)) || fifo_rd)
    else $error("output queue overflow");

  a_credit_covers_queue: assert property (@(posedge clk) disable iff (rst)
    fcnt <= credit)
    else $error("queued results exceed credits");

  a_result_inside_frame: assert property (@(posedge clk) disable iff (rst)
    s3.vld |-> (s3.row < $signed(ROW_W'(eff_h))))
    else $error("result row beyond frame");

  a_drain_yields_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && pix_done) |=> s0.vld)
    else $error("accepted drain without cascade advance");

endmodule

FILE: bench/binary_threshold_erode_erode_dilate_tb.sv
module binary_threshold_erode_erode_dilate_tb;
  import bted_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = WIN * MAX_WIDTH;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic pready;
  logic in_valid;
  logic in_ready;
  logic command;
  logic [PIX_W-1:0] pixel_in;
  logic out_valid;
  logic out_ready;
  logic [PIX_W-1:0] pixel_out;
  logic [OROW_W-1:0] out_row;
  logic [COL_W-1:0] out_column;
  logic frame_last;

  binary_threshold_erode_erode_dilate DUT (.*);

  // mirror of the block state
  bit mask_store [3][DEPTH];
  logic [PIX_W-1:0] thr_reg;
  logic [WID_W-1:0] width_reg;
  logic [HGT_W-1:0] height_reg;
  int unsigned pix_count;

  result_t pixel_queue[$];
  int errors;
  int results_seen;
  int frames_done;
  bit quiet;
  bit frame_closed;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("binary_threshold_erode_erode_dilate regression: fail");
    $finish;
  end

  function automatic int unsigned cur_w();
    if (width_reg < 1) return 1;
    if (width_reg > MAX_WIDTH) return MAX_WIDTH;
    return int'(width_reg);
  endfunction

  function automatic int unsigned cur_h();
    if (height_reg < 1) return 1;
    if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
    return int'(height_reg);
  endfunction

  function automatic bit window_or_and(int src, int unsigned s, int w, int h, bit dil);
    int r;
    int c;
    int rr;
    int cc;
    bit acc;
    r = s / w;
    c = s % w;
    acc = !dil;
    for (int dr = -RADIUS; dr <= RADIUS; dr++) begin
      rr = r + dr;
      if (rr < 0 || rr >= h) continue;
      for (int dc = -RADIUS; dc <= RADIUS; dc++) begin
        cc = c + dc;
        if (cc < 0 || cc >= w) continue;
        if (dil) acc |= mask_store[src][(rr * w + cc) % DEPTH];
        else acc &= mask_store[src][(rr * w + cc) % DEPTH];
      end
    end
    return acc;
  endfunction

  function automatic bit cascade_step(logic [PIX_W-1:0] px, output result_t res);
    int unsigned w;
    int unsigned h;
    int unsigned total;
    int unsigned lag;
    int unsigned t;
    int unsigned s;
    w = cur_w();
    h = cur_h();
    total = w * h;
    lag = RADIUS * w + RADIUS;
    t = pix_count;
    res = '0;
    if (t < total) mask_store[0][t % DEPTH] = px > thr_reg;
    for (int k = 1; k <= 2; k++) begin
      if (t >= k * lag && t - k * lag < total) begin
        s = t - k * lag;
        mask_store[k][s % DEPTH] = window_or_and(k - 1, s, w, h, 0);
      end
    end
    pix_count = t + 1;
    if (t >= 3 * lag && t - 3 * lag < total) begin
      s = t - 3 * lag;
      res.pixel = window_or_and(2, s, w, h, 1) ? PIX_ON : PIX_OFF;
      res.row = OROW_W'(s / w);
      res.col = COL_W'(s % w);
      res.last = (s == total - 1);
      if (res.last) pix_count = 0;
      return 1;
    end
    return 0;
  endfunction

  function automatic bit predict_pixel(bit cmd, logic [PIX_W-1:0] px, output result_t res);
    int unsigned total;
    int unsigned guard;
    total = cur_w() * cur_h();
    guard = 3 * (RADIUS * cur_w() + RADIUS) + 2;
    res = '0;
    if (pix_count < total) begin
      if (!cmd) return cascade_step(px, res);
      return 0;
    end
    while (guard > 0) begin
      if (cascade_step(8'd0, res)) return 1;
      guard--;
    end
    return 0;
  endfunction

  task automatic idle_cycles(int n);
    repeat (n) @(posedge clk);
  endtask

  task automatic send_pixel(bit cmd, logic [PIX_W-1:0] px);
    result_t res;
    in_valid <= 1;
    command <= cmd;
    pixel_in <= px;
    do @(posedge clk); while (!in_ready);
    if (predict_pixel(cmd, px, res)) begin
      pixel_queue.push_back(res);
      if (res.last) frame_closed = 1;
    end
    if (!quiet && $urandom_range(3) == 0) begin
      in_valid <= 0;
      idle_cycles($urandom_range(1, 15));
    end
  endtask

  task automatic wait_drained();
    in_valid <= 0;
    while (pixel_queue.size() != 0) @(posedge clk);
    idle_cycles(LAG_MUL * cur_w() + 64);
  endtask

  task automatic reg_write(reg_idx_t idx, logic [DATA_W-1:0] val);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= ADDR_W'(4 * idx);
    pwdata <= val;
    @(posedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    psel <= 0;
    penable <= 0;
    case (idx)
      REG_THRESHOLD: thr_reg = val[PIX_W-1:0];
      REG_WIDTH: begin
        width_reg = val[WID_W-1:0];
        pix_count = 0;
      end
      default: begin
        height_reg = val[HGT_W-1:0];
        pix_count = 0;
      end
    endcase
    @(posedge clk);
  endtask

  task automatic reg_check(reg_idx_t idx, logic [DATA_W-1:0] want);
    psel <= 1;
    penable <= 0;
    pwrite <= 0;
    paddr <= ADDR_W'(4 * idx);
    @(posedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    if (prdata !== want) begin
      errors++;
      if (errors <= 10)
        $display("register %0d: expected %0h, got %0h", idx, want, prdata);
    end
    psel <= 0;
    penable <= 0;
    @(posedge clk);
  endtask

  task automatic set_geometry(int w, int h);
    wait_drained();
    reg_write(REG_WIDTH, w);
    reg_write(REG_HEIGHT, h);
  endtask

  // fg_pct: chance that a pixel lands above threshold
  task automatic run_frame(int fg_pct, int noise_pct);
    int unsigned total;
    logic [PIX_W-1:0] px;
    total = cur_w() * cur_h();
    frame_closed = 0;
    for (int unsigned i = 0; i < total; i++) begin
      if ($urandom_range(99) < noise_pct) send_pixel(1, PIX_W'($urandom));
      if ($urandom_range(99) < fg_pct && thr_reg != 8'hff)
        px = PIX_W'($urandom_range(thr_reg + 1, 255));
      else
        px = PIX_W'($urandom_range(0, thr_reg));
      send_pixel(0, px);
    end
    // pixels sent after frame end act as drains
    while (!frame_closed) send_pixel($urandom_range(3) != 0, PIX_W'($urandom));
    frames_done++;
  endtask

  task automatic test_register_reset();
    reg_check(REG_THRESHOLD, THRESHOLD_RESET);
    reg_check(REG_WIDTH, WIDTH_RESET);
    reg_check(REG_HEIGHT, HEIGHT_RESET);
  endtask

  task automatic test_threshold_extremes();
    set_geometry(3, 2);
    reg_write(REG_THRESHOLD, 0);
    reg_check(REG_THRESHOLD, 0);
    frame_closed = 0;
    send_pixel(0, 8'd0);
    send_pixel(0, 8'd1);
    send_pixel(0, 8'd255);
    send_pixel(1, 8'd0);
    send_pixel(0, 8'd128);
    send_pixel(0, 8'd0);
    send_pixel(0, 8'd254);
    while (!frame_closed) send_pixel(1, 8'd0);
    wait_drained();
    reg_write(REG_THRESHOLD, 255);
    run_frame(50, 10);
    wait_drained();
    reg_write(REG_THRESHOLD, 100);
  endtask

  task automatic test_tiny_and_saturated();
    set_geometry(1, 1);
    run_frame(100, 0);
    set_geometry(0, 0);
    run_frame(100, 20);
    set_geometry(0, 3);
    run_frame(100, 10);
    set_geometry(4, 0);
    run_frame(100, 10);
  endtask

  task automatic test_abandon_frame();
    set_geometry(6, 6);
    for (int i = 0; i < 20; i++) send_pixel(0, PIX_W'($urandom));
    set_geometry(7, 5);
    reg_check(REG_WIDTH, 7);
    run_frame(95, 5);
  endtask

  task automatic test_random_frames();
    int sent;
    sent = 0;
    while (sent < 1400) begin
      if ($urandom_range(4) == 0) begin
        wait_drained();
        reg_write(REG_THRESHOLD, $urandom);
      end
      if (sent > 1100) quiet = 1;
      set_geometry($urandom_range(1, 12), $urandom_range(1, 10));
      run_frame($urandom_range(80, 100), $urandom_range(0, 5));
      sent += cur_w() * cur_h() * 2;
    end
  endtask

  initial begin
    out_ready <= 0;
    @(negedge rst);
    forever begin
      out_ready <= 1;
      idle_cycles($urandom_range(1, 20));
      if (!quiet) begin
        out_ready <= 0;
        idle_cycles($urandom_range(1, 15));
      end
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (pixel_queue.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result at row %0d col %0d", out_row, out_column);
      end else begin
        want = pixel_queue.pop_front();
        if (pixel_out !== want.pixel || out_row !== want.row ||
            out_column !== want.col || frame_last !== want.last) begin
          errors++;
          if (errors <= 10)
            $display("expected pix %0d r %0d c %0d last %0b, got pix %0d r %0d c %0d last %0b",
                     want.pixel, want.row, want.col, want.last,
                     pixel_out, out_row, out_column, frame_last);
        end
      end
    end
  end

  initial begin
    rst = 1;
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = '0;
    pwdata = '0;
    in_valid = 0;
    command = 0;
    pixel_in = '0;
    errors = 0;
    results_seen = 0;
    frames_done = 0;
    quiet = 0;
    thr_reg = THRESHOLD_RESET;
    width_reg = WIDTH_RESET;
    height_reg = HEIGHT_RESET;
    pix_count = 0;
    foreach (mask_store[i, j]) mask_store[i][j] = 0;
    idle_cycles(12);
    rst <= 0;
    @(posedge clk);
    test_register_reset();
    test_threshold_extremes();
    test_tiny_and_saturated();
    test_abandon_frame();
    test_random_frames();
    in_valid <= 0;
    while (pixel_queue.size() != 0) @(posedge clk);
    idle_cycles(100);
    $display("covered %0d frames and %0d result pixels, geometry from 1x1 to 12x10",
             frames_done, results_seen);
    $display("zero width and height clamp, mid-frame abandon and threshold extremes included");
    $display("mismatches: %0d", errors);
    if (errors == 0) begin
      $display("binary_threshold_erode_erode_dilate regression: pass");
    end else begin
      $display("binary_threshold_erode_erode_dilate regression: fail");
    end
    $finish;
  end

endmodule

FILE: binary_threshold_erode_erode_dilate.f
src/bted_pkg.sv
src/bted_ram.sv
src/bted_stage.sv
src/binary_threshold_erode_erode_dilate.sv
bench/binary_threshold_erode_erode_dilate_tb.sv
